@@ hdl/steer_angle_wheel_duty_split_unit_defines.svh @@
// assertion macros for the steering duty split unit
`ifndef STEER_ANGLE_WHEEL_DUTY_SPLIT_UNIT_DEFINES_SVH
`define STEER_ANGLE_WHEEL_DUTY_SPLIT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SWDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SWDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWDS_ASSERT_IMP(label, ante, cons, msg)
`define SWDS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ hdl/swds_pkg.sv @@
// shared types and constants for the steering duty split unit
`timescale 1ns / 1ps
package swds_pkg;

    localparam int ADC_BITS_DEF  = 12;
    localparam int DUTY_BITS_DEF = 16;

    localparam int FS_MAX_W   = 12;
    localparam int MRAD_W     = 10;
    localparam int GAIN_W     = 16;
    localparam int DUTY_MAX_W = 16;
    localparam int ANG_W      = 15;
    localparam int POLY_W     = 16;
    localparam int RATIO_W    = 15;
    localparam int Q_FRAC     = 14;
    localparam int GAIN_FRAC  = 16;
    localparam int Q14_ONE    = 16384;
    localparam int MRAD_SCALE = 1000;

    localparam int TAN_C9 = 358;
    localparam int TAN_C7 = 884;
    localparam int TAN_C5 = 2185;
    localparam int TAN_C3 = 5461;

    localparam int FS_RST       = 4095;
    localparam int MRAD_RST     = 524;
    localparam int GAIN_RST     = 13653;
    localparam int DUTY_MAX_RST = 1000;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_FULL_SCALE = 2'd0,
        REG_MAX_ANGLE  = 2'd1,
        REG_GAIN       = 2'd2,
        REG_DUTY_MAX   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [FS_MAX_W-1:0]   full_scale;
        logic [MRAD_W-1:0]     max_mrad;
        logic [GAIN_W-1:0]     gain;
        logic [DUTY_MAX_W-1:0] duty_max;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             pos;
        logic [ANG_W-1:0] mag;
    } ang_t;

    typedef struct packed {
        logic [DUTY_MAX_W-1:0] left;
        logic [DUTY_MAX_W-1:0] right;
        logic                  turn;
    } res_t;

endpackage

@@ hdl/swds_cfg.sv @@
// apb register file for the steering duty split unit
`timescale 1ns / 1ps
module swds_cfg
    import swds_pkg::*;
#(
    parameter int ADC_BITS  = ADC_BITS_DEF,
    parameter int DUTY_BITS = DUTY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    localparam int FS_W = (ADC_BITS < FS_MAX_W) ? ADC_BITS : FS_MAX_W;

    logic [FS_W-1:0]      fs_reg,   fs_next;
    logic [MRAD_W-1:0]    mrad_reg, mrad_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;
    logic [DUTY_BITS-1:0] duty_reg, duty_next;
    logic                 wr;
    reg_idx_t             idx;

    assign wr  = psel & penable & pwrite;
    assign idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        fs_next   = fs_reg;
        mrad_next = mrad_reg;
        gain_next = gain_reg;
        duty_next = duty_reg;
        if (wr)
        begin
            case (idx)
                REG_FULL_SCALE: fs_next   = pwdata[FS_W-1:0];
                REG_MAX_ANGLE:  mrad_next = pwdata[MRAD_W-1:0];
                REG_GAIN:       gain_next = pwdata[GAIN_W-1:0];
                REG_DUTY_MAX:   duty_next = pwdata[DUTY_BITS-1:0];
                default:        fs_next   = fs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg   <= FS_W'(FS_RST);
            mrad_reg <= MRAD_W'(MRAD_RST);
            gain_reg <= GAIN_W'(GAIN_RST);
            duty_reg <= DUTY_BITS'(DUTY_MAX_RST);
        end
        else
        begin
            fs_reg   <= fs_next;
            mrad_reg <= mrad_next;
            gain_reg <= gain_next;
            duty_reg <= duty_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_FULL_SCALE: prdata = APB_DATA_W'(fs_reg);
            REG_MAX_ANGLE:  prdata = APB_DATA_W'(mrad_reg);
            REG_GAIN:       prdata = APB_DATA_W'(gain_reg);
            REG_DUTY_MAX:   prdata = APB_DATA_W'(duty_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.full_scale = FS_MAX_W'(fs_reg);
    assign cfg.max_mrad   = mrad_reg;
    assign cfg.gain       = gain_reg;
    assign cfg.duty_max   = DUTY_MAX_W'(duty_reg);

endmodule

@@ hdl/swds_angle.sv @@
// sample clamp, angle scaling and pipelined restoring divider
`timescale 1ns / 1ps
module swds_angle
    import swds_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [ADC_BITS-1:0] in_sample,
    input  cfg_t                cfg,
    output ang_t                ang_out
);

    localparam int FS_W   = (ADC_BITS < FS_MAX_W) ? ADC_BITS : FS_MAX_W;
    localparam int PROD_W = FS_W + MRAD_W;
    localparam int NUM_W  = PROD_W + Q_FRAC;
    localparam int DIV_W  = FS_W + MRAD_W;

    logic [FS_W-1:0]  fs_eff;
    logic [FS_W-1:0]  fs_reg;
    logic [DIV_W-1:0] div_reg;

    logic             v1_reg, v2_reg, v3_reg;
    logic [FS_W-1:0]  s1_reg;
    logic [FS_W-1:0]  dist2_reg;
    logic             pos2_reg, pos3_reg;
    logic [PROD_W-1:0] prod3_reg;

    logic [FS_W:0]    two_s;
    logic [FS_W:0]    fs_x;
    logic             gt;
    logic [FS_W:0]    diff;

    logic [NUM_W-1:0] rem_in  [ANG_W];
    logic [ANG_W-1:0] q_in    [ANG_W];
    logic             pos_in  [ANG_W];
    logic             v_in    [ANG_W];
    logic [NUM_W-1:0] rem_reg [ANG_W-1];
    logic [ANG_W-1:0] q_reg   [ANG_W];
    logic             pos_reg [ANG_W];
    logic             v_reg   [ANG_W];

    // zero full scale acts as one
    assign fs_eff = (cfg.full_scale[FS_W-1:0] == '0) ? FS_W'(1) : cfg.full_scale[FS_W-1:0];

    always_ff @(posedge clk)
    begin
        fs_reg  <= fs_eff;
        div_reg <= DIV_W'(fs_eff) * DIV_W'(MRAD_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign two_s = {s1_reg, 1'b0};
    assign fs_x  = {1'b0, fs_reg};
    assign gt    = two_s > fs_x;
    assign diff  = gt ? (two_s - fs_x) : (fs_x - two_s);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= (in_sample > ADC_BITS'(fs_eff)) ? fs_eff : in_sample[FS_W-1:0];
            dist2_reg <= diff[FS_W-1:0];
            pos2_reg  <= gt;
            prod3_reg <= PROD_W'(dist2_reg) * PROD_W'(cfg.max_mrad);
            pos3_reg  <= pos2_reg;
        end
    end

    // one quotient bit per stage, msb first
    genvar j;
    generate
        for (j = 0; j < ANG_W; j++)
        begin : g_div
            localparam int SH = ANG_W - 1 - j;
            logic [NUM_W-1:0] dsh;
            logic             ge;

            if (j == 0)
            begin : g_first
                assign rem_in[j] = {prod3_reg, Q_FRAC'(0)};
                assign q_in[j]   = '0;
                assign pos_in[j] = pos3_reg;
                assign v_in[j]   = v3_reg;
            end
            else
            begin : g_next
                assign rem_in[j] = rem_reg[j-1];
                assign q_in[j]   = q_reg[j-1];
                assign pos_in[j] = pos_reg[j-1];
                assign v_in[j]   = v_reg[j-1];
            end

            assign dsh = NUM_W'(div_reg) << SH;
            assign ge  = rem_in[j] >= dsh;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[j] <= v_in[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[j]   <= {q_in[j][ANG_W-2:0], ge};
                    pos_reg[j] <= pos_in[j];
                end
            end

            if (j < ANG_W - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j] <= ge ? (rem_in[j] - dsh) : rem_in[j];
                    end
                end
            end
        end
    endgenerate

    assign ang_out.valid = v_reg[ANG_W-1];
    assign ang_out.pos   = pos_reg[ANG_W-1];
    assign ang_out.mag   = q_reg[ANG_W-1];

endmodule

@@ hdl/swds_tan.sv @@
// tan polynomial, inner wheel ratio and duty scaling pipeline
`timescale 1ns / 1ps
module swds_tan
    import swds_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  ang_t ang_in,
    input  cfg_t cfg,
    output logic res_valid,
    output res_t res
);

    localparam int NSTG = 8;

    function automatic logic [POLY_W-1:0] horner(input logic [POLY_W-1:0] x2,
                                                 input logic [POLY_W-1:0] p,
                                                 input logic [POLY_W-1:0] c);
        logic [2*POLY_W-1:0] m;
        m = {{POLY_W{1'b0}}, x2} * {{POLY_W{1'b0}}, p};
        return c + m[Q_FRAC+POLY_W-1:Q_FRAC];
    endfunction

    logic                v_reg [NSTG];

    logic [2*ANG_W-1:0]  sq;
    logic [2*POLY_W-1:0] tp;
    logic [2*POLY_W-1:0] kp;
    logic [POLY_W-1:0]   kt;
    logic [RATIO_W+DUTY_BITS-1:0] dp;
    logic [DUTY_BITS-1:0] duty;
    logic [DUTY_BITS-1:0] inner;

    logic [ANG_W-1:0]  x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic [POLY_W-1:0] sq1_reg, sq2_reg, sq3_reg, sq4_reg;
    logic [POLY_W-1:0] p2_reg, p3_reg, p4_reg, p5_reg;
    logic [POLY_W-1:0] t6_reg;
    logic [RATIO_W-1:0] r7_reg;
    logic              pos_reg [NSTG-1];
    res_t              res_reg;

    assign sq    = {{ANG_W{1'b0}}, ang_in.mag} * {{ANG_W{1'b0}}, ang_in.mag};
    assign tp    = {{(2*POLY_W-ANG_W){1'b0}}, x5_reg} * {{POLY_W{1'b0}}, p5_reg};
    assign kp    = {{(2*POLY_W-GAIN_W){1'b0}}, cfg.gain} * {{POLY_W{1'b0}}, t6_reg};
    assign kt    = kp[GAIN_FRAC+POLY_W-1:GAIN_FRAC];
    assign duty  = cfg.duty_max[DUTY_BITS-1:0];
    assign dp    = (RATIO_W+DUTY_BITS)'(r7_reg) * (RATIO_W+DUTY_BITS)'(duty);
    assign inner = dp[Q_FRAC+DUTY_BITS-1:Q_FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= ang_in.valid;
            for (int i = 1; i < NSTG; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // angle that truncates to zero counts as straight ahead
            pos_reg[0] <= ang_in.pos & (ang_in.mag != '0);
            for (int i = 1; i < NSTG - 1; i++)
            begin
                pos_reg[i] <= pos_reg[i-1];
            end

            x1_reg  <= ang_in.mag;
            sq1_reg <= sq[Q_FRAC+POLY_W-1:Q_FRAC];

            x2_reg  <= x1_reg;
            sq2_reg <= sq1_reg;
            p2_reg  <= horner(sq1_reg, POLY_W'(TAN_C9), POLY_W'(TAN_C7));

            x3_reg  <= x2_reg;
            sq3_reg <= sq2_reg;
            p3_reg  <= horner(sq2_reg, p2_reg, POLY_W'(TAN_C5));

            x4_reg  <= x3_reg;
            sq4_reg <= sq3_reg;
            p4_reg  <= horner(sq3_reg, p3_reg, POLY_W'(TAN_C3));

            x5_reg  <= x4_reg;
            p5_reg  <= horner(sq4_reg, p4_reg, POLY_W'(Q14_ONE));

            t6_reg  <= tp[Q_FRAC+POLY_W-1:Q_FRAC];

            // inner ratio saturates at zero
            r7_reg  <= (kt >= POLY_W'(Q14_ONE)) ? '0 : RATIO_W'(POLY_W'(Q14_ONE) - kt);

            res_reg.turn  <= pos_reg[NSTG-2];
            res_reg.left  <= pos_reg[NSTG-2] ? DUTY_MAX_W'(duty) : DUTY_MAX_W'(inner);
            res_reg.right <= pos_reg[NSTG-2] ? DUTY_MAX_W'(inner) : DUTY_MAX_W'(duty);
        end
    end

    assign res_valid = v_reg[NSTG-1];
    assign res       = res_reg;

endmodule

@@ hdl/steer_angle_wheel_duty_split_unit.sv @@
// top level of the steering angle to wheel duty split unit
//
// one steering adc sample per item enters on s_axis (tdata holds adc_sample);
// one result per item leaves on m_axis: tdata holds duty_left then duty_right,
// tuser holds turning_right. configuration sits behind the apb port: full
// scale at 0x0, max angle in mrad at 0x4, geometry gain at 0x8, duty max at 0xc.
// the datapath is a fixed pipeline: clamp, distance, angle product, fifteen
// divider stages (one quotient bit each), then eight stages of tan polynomial,
// ratio and duty scaling. a result shows on m_axis_tvalid once its item has passed
// these stages and the output register; one item is taken every cycle while the
// output drains. the divider chain is the longest part of the pipeline.
// when m_axis_tready is low the output register holds its item and a skid
// register catches one more; s_axis_tready then drops and the whole pipeline
// freezes until the skid register empties. nothing is lost or repeated.
// reset clears all valid bits and loads the register defaults
// (4095, 524, 13653, 1000). write registers only while no item is in flight.
`timescale 1ns / 1ps
`include "steer_angle_wheel_duty_split_unit_defines.svh"
module steer_angle_wheel_duty_split_unit
    import swds_pkg::*;
#(
    parameter int ADC_BITS  = ADC_BITS_DEF,
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    localparam int IN_TD_W  = ((ADC_BITS + 7) / 8) * 8,
    localparam int OUT_TD_W = ((2 * DUTY_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TD_W-1:0]    s_axis_tdata,   // adc_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_TD_W-1:0]   m_axis_tdata,   // duty_left, duty_right
    output logic                  m_axis_tuser,   // turning_right
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    ang_t ang;
    logic en;
    logic pipe_valid;
    res_t pipe_res;
    logic take;

    logic out_valid_reg,  out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg,  out_next;
    res_t skid_reg, skid_next;

    assign pready = 1'b1;

    swds_cfg #(
        .ADC_BITS  (ADC_BITS),
        .DUTY_BITS (DUTY_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    swds_angle #(
        .ADC_BITS (ADC_BITS)
    ) u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_sample (s_axis_tdata[ADC_BITS-1:0]),
        .cfg       (cfg),
        .ang_out   (ang)
    );

    swds_tan #(
        .DUTY_BITS (DUTY_BITS)
    ) u_tan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ang_in    (ang),
        .cfg       (cfg),
        .res_valid (pipe_valid),
        .res       (pipe_res)
    );

    // pipeline runs while the skid register is free
    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;
    assign take          = pipe_valid & en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                out_next       = pipe_res;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_next       = pipe_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TD_W'({out_reg.right[DUTY_BITS-1:0],
                                      out_reg.left[DUTY_BITS-1:0]});
    assign m_axis_tuser  = out_reg.turn;

    `SWDS_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid item with empty output")
    `SWDS_ASSERT_NXT(a_stall_fills_skid, out_valid_reg && !m_axis_tready && take, skid_valid_reg, "stalled item not caught")
    `SWDS_ASSERT_IMP(a_right_inner, out_valid_reg && out_reg.turn, out_reg.left >= out_reg.right, "right turn with faster right wheel")
    `SWDS_ASSERT_IMP(a_left_inner, out_valid_reg && !out_reg.turn, out_reg.right >= out_reg.left, "left turn with faster left wheel")

endmodule
